[rtl/trajectory_playback_interpolator_unit_assert.svh]
// Assertion macros used by the playback interpolator datapath.
`ifndef TRAJECTORY_PLAYBACK_INTERPOLATOR_UNIT_ASSERT_SVH
`define TRAJECTORY_PLAYBACK_INTERPOLATOR_UNIT_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define TPI_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tpi check failed");

// next-cycle implication
`define TPI_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tpi check failed");

`endif

[rtl/tpi_pkg.sv]
// Shared types and constants of the playback interpolator.
`default_nettype none
package tpi_pkg;

  localparam int FRAC_BITS = 36;
  localparam int JIDX_W    = 5;
  localparam int BFRM_W    = 10;

  // configuration register indexes
  localparam logic [2:0] CFG_FRAME_COUNT = 3'd0;
  localparam logic [2:0] CFG_JOINT_COUNT = 3'd1;
  localparam logic [2:0] CFG_FRAME_RATE  = 3'd2;
  localparam logic [2:0] CFG_SPEED       = 3'd3;
  localparam logic [2:0] CFG_LOOP_EN     = 3'd4;
  localparam logic [2:0] CFG_PAUSE_TIME  = 3'd5;

  // reset values
  localparam logic [10:0] RST_FRAME_COUNT = 11'd1;
  localparam logic [5:0]  RST_JOINT_COUNT = 6'd1;
  localparam logic [15:0] RST_FRAME_RATE  = 16'd12800;
  localparam logic [15:0] RST_SPEED       = 16'd4096;

  typedef struct packed {
    logic [10:0] frame_count;
    logic [5:0]  joint_count;
    logic [15:0] frame_rate;
    logic [15:0] speed;
    logic        loop_enable;
    logic [31:0] pause_time;
  } tpi_cfg_t;

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_MUL_RS = 9'b000000010,
    ST_MUL_P  = 9'b000000100,
    ST_MUL_PZ = 9'b000001000,
    ST_SETUP  = 9'b000010000,
    ST_DIV    = 9'b000100000,
    ST_CLAMP  = 9'b001000000,
    ST_ISSUE  = 9'b010000000,
    ST_DRAIN  = 9'b100000000
  } tpi_state_t;

  typedef struct packed {
    logic load;
    logic start;
    logic mul_rs;
    logic mul_p;
    logic mul_pz;
    logic setup;
    logic div_step;
    logic clamp;
    logic issue;
  } tpi_cmd_t;

  typedef struct packed {
    logic do_div;
    logic div_last;
    logic adv;
    logic last_joint;
    logic pipe_empty;
  } tpi_stat_t;

endpackage
`default_nettype wire

[rtl/tpi_ctrl.sv]
// Sequencer of the playback interpolator: setup, modulo, joint issue.
`default_nettype none
module tpi_ctrl
  import tpi_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire logic      in_kind,
  output logic           in_stall,
  input  var  tpi_stat_t st,
  output tpi_cmd_t       cmd
);

  tpi_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_kind) begin
            cmd.start = 1'b1;
            state_nxt = ST_MUL_RS;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      ST_MUL_RS: begin
        cmd.mul_rs = 1'b1;
        state_nxt  = ST_MUL_P;
      end
      ST_MUL_P: begin
        cmd.mul_p = 1'b1;
        state_nxt = ST_MUL_PZ;
      end
      ST_MUL_PZ: begin
        cmd.mul_pz = 1'b1;
        state_nxt  = ST_SETUP;
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (!st.do_div) begin
          state_nxt = ST_CLAMP;
        end else begin
          cmd.div_step = 1'b1;
          if (st.div_last) state_nxt = ST_CLAMP;
        end
      end
      ST_CLAMP: begin
        cmd.clamp = 1'b1;
        state_nxt = ST_ISSUE;
      end
      ST_ISSUE: begin
        if (st.adv) begin
          cmd.issue = 1'b1;
          if (st.last_joint) state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (st.pipe_empty) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

[rtl/tpi_dp.sv]
// Datapath: scaling, bit-serial modulo, clamp, frame table and blend pipeline.
`default_nettype none
`include "trajectory_playback_interpolator_unit_assert.svh"
module tpi_dp
  import tpi_pkg::*;
#(
  parameter int MAX_FRAMES = 1024,
  parameter int MAX_JOINTS = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  var  tpi_cfg_t           cfg,
  input  var  tpi_cmd_t           cmd,
  output tpi_stat_t               st,
  input  wire logic [31:0]        in_elapsed_time,
  input  wire logic [9:0]         in_load_frame,
  input  wire logic [4:0]         in_load_joint,
  input  wire logic signed [15:0] in_load_position,
  input  wire logic signed [15:0] in_load_velocity,
  input  wire logic               out_stall,
  output logic                    out_valid,
  output logic [4:0]              out_joint_index,
  output logic signed [15:0]      out_position,
  output logic signed [15:0]      out_velocity,
  output logic [9:0]              out_base_frame,
  output logic [15:0]             out_blend_weight,
  output logic                    out_holding,
  output logic                    out_last
);

  localparam int F_W   = $clog2(MAX_FRAMES + 1);
  localparam int B_W   = $clog2(MAX_FRAMES);
  localparam int J_W   = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
  localparam int NJ_W  = $clog2(MAX_JOINTS + 1);
  localparam int DEPTH = MAX_FRAMES * MAX_JOINTS;
  localparam int A_W   = $clog2(DEPTH);

  // effective counts
  logic [F_W-1:0]  f_eff;
  logic [NJ_W-1:0] nj_eff;

  always_comb begin
    if (cfg.frame_count == '0) f_eff = F_W'(1);
    else if (32'(cfg.frame_count) > MAX_FRAMES) f_eff = F_W'(MAX_FRAMES);
    else f_eff = F_W'(cfg.frame_count);
    if (cfg.joint_count == '0) nj_eff = NJ_W'(1);
    else if (32'(cfg.joint_count) > MAX_JOINTS) nj_eff = NJ_W'(MAX_JOINTS);
    else nj_eff = NJ_W'(cfg.joint_count);
  end

  // scaling and modulo
  logic [31:0] t_r, rs_r;
  logic [63:0] p_r, pz_r, d_r, rem_r;
  logic [5:0]  cnt_r;
  logic        do_div_r;
  logic [31:0] mul_a;
  logic [63:0] mul_y;
  logic [63:0] frames_fix;
  logic [64:0] cyc_sum, r2, r_diff;
  logic [63:0] r_new;

  assign mul_a      = cmd.mul_p ? t_r : cfg.pause_time;
  assign mul_y      = mul_a * rs_r;
  assign frames_fix = 64'(f_eff) << FRAC_BITS;
  assign cyc_sum    = {1'b0, frames_fix} + {1'b0, pz_r};
  assign r2         = {rem_r, p_r[63]};
  assign r_diff     = r2 - {1'b0, d_r};
  assign r_new      = r_diff[64] ? r2[63:0] : r_diff[63:0];

  // clamp to the table and derive the blend weight
  logic [27:0] ip, f28, fm1, pi, up28;
  logic [35:0] frac, pf;
  logic        hold_c, gt_c;
  logic [16:0] w17;
  logic [B_W-1:0] base_r, upper_r;
  logic [15:0] w_r;
  logic        hold_r;

  always_comb begin
    ip     = p_r[63:36];
    frac   = p_r[35:0];
    f28    = 28'(f_eff);
    fm1    = f28 - 28'd1;
    hold_c = (ip >= f28);
    gt_c   = hold_c || (ip > fm1) || ((ip == fm1) && (frac != '0));
    pi     = gt_c ? fm1 : ip;
    pf     = gt_c ? '0 : frac;
    up28   = ((pi + 28'd1) < f28) ? (pi + 28'd1) : fm1;
    w17    = {1'b0, pf[35:20]} + 17'(pf[19]);
  end

  always_ff @(posedge clk) begin
    if (cmd.start) t_r <= in_elapsed_time;
    if (cmd.mul_rs) rs_r <= 32'(cfg.speed) * 32'(cfg.frame_rate);
    if (cmd.mul_p) p_r <= mul_y;
    if (cmd.mul_pz) pz_r <= mul_y;
    if (cmd.setup) begin
      d_r   <= cyc_sum[63:0];
      rem_r <= '0;
      cnt_r <= 6'd63;
    end
    if (cmd.div_step) begin
      rem_r <= r_new;
      cnt_r <= cnt_r - 6'd1;
      p_r   <= (cnt_r == '0) ? r_new : {p_r[62:0], 1'b0};
    end
    if (cmd.clamp) begin
      base_r  <= B_W'(pi);
      upper_r <= B_W'(up28);
      w_r     <= w17[16] ? 16'hFFFF : w17[15:0];
      hold_r  <= hold_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) do_div_r <= 1'b0;
    else if (cmd.setup) do_div_r <= cfg.loop_enable && !cyc_sum[64];
  end

  // joint counter
  logic [J_W-1:0] j_r;
  logic           last_joint;

  assign last_joint = ((NJ_W'(j_r) + NJ_W'(1)) == nj_eff);

  always_ff @(posedge clk) begin
    if (!rst_n) j_r <= '0;
    else if (cmd.clamp) j_r <= '0;
    else if (cmd.issue) j_r <= j_r + J_W'(1);
  end

  // frame table, {position, velocity} per entry
  logic [31:0] mem [DEPTH];
  logic [A_W-1:0] wa, a0, a1;
  logic        ld_ok;

  assign ld_ok = (32'(in_load_frame) < MAX_FRAMES) && (32'(in_load_joint) < MAX_JOINTS);
  assign wa    = A_W'(32'(in_load_frame) * MAX_JOINTS + 32'(in_load_joint));
  assign a0    = A_W'(32'(base_r) * MAX_JOINTS + 32'(j_r));
  assign a1    = A_W'(32'(upper_r) * MAX_JOINTS + 32'(j_r));

  // blend pipeline: read, blend, scale, round
  logic adv;
  logic s1_v_r, s2_v_r, s3_v_r, out_valid_r;
  logic [31:0] rd0_r, rd1_r;
  logic [J_W-1:0] j1_r, j2_r, j3_r;
  logic l1_r, l2_r, l3_r;
  logic signed [33:0] pb_c, vb_c, pb_r, vb_r, pr_c;
  logic signed [17:0] sw, sh;
  logic signed [15:0] pos_c, pos3_r, vel_c;
  logic signed [50:0] vm_c, vm3_r, vr_c;

  assign adv = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.load && ld_ok) mem[wa] <= {in_load_position, in_load_velocity};
    if (adv && cmd.issue) begin
      rd0_r <= mem[a0];
      rd1_r <= mem[a1];
    end
  end

  always_comb begin
    sw   = $signed({1'b0, 17'd65536 - 17'(w_r)});
    sh   = $signed({2'b00, w_r});
    pb_c = sw * $signed(rd0_r[31:16]) + sh * $signed(rd1_r[31:16]);
    vb_c = sw * $signed(rd0_r[15:0]) + sh * $signed(rd1_r[15:0]);
    pr_c = (pb_r + 34'sd32768) >>> 16;
    if (pr_c > 34'sd32767) pos_c = 16'sh7FFF;
    else if (pr_c < -34'sd32768) pos_c = -16'sh8000;
    else pos_c = 16'(pr_c);
    vm_c = vb_r * $signed({1'b0, cfg.speed});
    vr_c = (vm3_r + 51'sd134217728) >>> 28;
    if (vr_c > 51'sd32767) vel_c = 16'sh7FFF;
    else if (vr_c < -51'sd32768) vel_c = -16'sh8000;
    else vel_c = 16'(vr_c);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_v_r      <= cmd.issue;
      s2_v_r      <= s1_v_r;
      s3_v_r      <= s2_v_r;
      out_valid_r <= s3_v_r;
    end
  end

  logic [4:0]         out_joint_index_r;
  logic signed [15:0] out_position_r, out_velocity_r;
  logic [9:0]         out_base_frame_r;
  logic [15:0]        out_blend_weight_r;
  logic               out_holding_r, out_last_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      j1_r   <= j_r;
      l1_r   <= last_joint;
      pb_r   <= pb_c;
      vb_r   <= vb_c;
      j2_r   <= j1_r;
      l2_r   <= l1_r;
      pos3_r <= pos_c;
      vm3_r  <= vm_c;
      j3_r   <= j2_r;
      l3_r   <= l2_r;
      out_joint_index_r  <= JIDX_W'(j3_r);
      out_position_r     <= pos3_r;
      out_velocity_r     <= hold_r ? 16'sd0 : vel_c;
      out_base_frame_r   <= BFRM_W'(base_r);
      out_blend_weight_r <= w_r;
      out_holding_r      <= hold_r;
      out_last_r         <= l3_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_joint_index  = out_joint_index_r;
  assign out_position     = out_position_r;
  assign out_velocity     = out_velocity_r;
  assign out_base_frame   = out_base_frame_r;
  assign out_blend_weight = out_blend_weight_r;
  assign out_holding      = out_holding_r;
  assign out_last         = out_last_r;

  assign st.do_div     = do_div_r;
  assign st.div_last   = (cnt_r == '0);
  assign st.adv        = adv;
  assign st.last_joint = last_joint;
  assign st.pipe_empty = !s1_v_r && !s2_v_r && !s3_v_r;

  `TPI_ASSERT_IMP(a_issue_in_range, cmd.issue, NJ_W'(j_r) < nj_eff)
  `TPI_ASSERT_NXT(a_stall_holds_read, s1_v_r && !adv, s1_v_r)
  `TPI_ASSERT_IMP(a_hold_zero_vel, out_valid_r && out_holding_r, out_velocity_r == 16'sd0)

endmodule
`default_nettype wire

[rtl/trajectory_playback_interpolator_unit.sv]
// Top level of the keyframe playback interpolator.
// Input channel (in_*): a request with in_kind 0 writes one table entry
//   (position, velocity) at in_load_frame/in_load_joint; entries
//   outside the table are dropped and produce no result.
// A request with in_kind 1 samples the table at in_elapsed_time and produces
//   one result per joint on the out_* channel, out_last set on the final one.
// Sequence of a sample: the setup states (speed-rate, position and pause
//   multiplies, modulo setup), the modulo state (the bit-serial modulo,
//   skipped when looping is off or the cycle length overflows), the clamp
//   state, then one joint issued per cycle while the output is not stalled,
//   into a 4-stage read/blend/scale/round pipeline. The next request is taken
//   only after the last result of the sample reaches the output register.
// in_stall is high from the cycle after a sample is accepted until the drain
//   state sees its last result in the output register; loads leave it low.
// A stalled out_* request freezes the whole joint pipeline; the output
//   register holds its payload until taken.
// Reset (rst_n low, synchronous) restores the configuration defaults and
//   empties the pipeline; the frame table is not cleared and must be loaded.
// Configuration writes (cfg_we) must be issued while idle; not enforced.
`default_nettype none
module trajectory_playback_interpolator_unit
  import tpi_pkg::*;
#(
  parameter int MAX_FRAMES = 1024,
  parameter int MAX_JOINTS = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_kind,
  input  wire logic [31:0]        in_elapsed_time,
  input  wire logic [9:0]         in_load_frame,
  input  wire logic [4:0]         in_load_joint,
  input  wire logic signed [15:0] in_load_position,
  input  wire logic signed [15:0] in_load_velocity,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [4:0]              out_joint_index,
  output logic signed [15:0]      out_position,
  output logic signed [15:0]      out_velocity,
  output logic [9:0]              out_base_frame,
  output logic [15:0]             out_blend_weight,
  output logic                    out_holding,
  output logic                    out_last
);

  // configuration registers
  tpi_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_count <= RST_FRAME_COUNT;
      cfg_r.joint_count <= RST_JOINT_COUNT;
      cfg_r.frame_rate  <= RST_FRAME_RATE;
      cfg_r.speed       <= RST_SPEED;
      cfg_r.loop_enable <= 1'b0;
      cfg_r.pause_time  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_COUNT: cfg_r.frame_count <= cfg_data[10:0];
        CFG_JOINT_COUNT: cfg_r.joint_count <= cfg_data[5:0];
        CFG_FRAME_RATE:  cfg_r.frame_rate  <= cfg_data[15:0];
        CFG_SPEED:       cfg_r.speed       <= cfg_data[15:0];
        CFG_LOOP_EN:     cfg_r.loop_enable <= cfg_data[0];
        CFG_PAUSE_TIME:  cfg_r.pause_time  <= cfg_data;
        default: ;
      endcase
    end
  end

  tpi_cmd_t  cmd;
  tpi_stat_t st;

  tpi_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_kind),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  tpi_dp #(
    .MAX_FRAMES (MAX_FRAMES),
    .MAX_JOINTS (MAX_JOINTS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .cmd              (cmd),
    .st               (st),
    .in_elapsed_time  (in_elapsed_time),
    .in_load_frame    (in_load_frame),
    .in_load_joint    (in_load_joint),
    .in_load_position (in_load_position),
    .in_load_velocity (in_load_velocity),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_joint_index  (out_joint_index),
    .out_position     (out_position),
    .out_velocity     (out_velocity),
    .out_base_frame   (out_base_frame),
    .out_blend_weight (out_blend_weight),
    .out_holding      (out_holding),
    .out_last         (out_last)
  );

endmodule
`default_nettype wire

[bench/trajectory_playback_interpolator_unit_tb.sv]
// Self-checking testbench for the keyframe playback interpolator.
`timescale 1ns / 1ps
`default_nettype none
module trajectory_playback_interpolator_unit_tb
  import tpi_pkg::*;
();

  localparam int TBL_FRAMES = 1024;
  localparam int TBL_JOINTS = 32;

  // one joint result as seen on out_*
  typedef struct packed {
    logic [4:0]         jidx;
    logic signed [15:0] pos;
    logic signed [15:0] vel;
    logic [9:0]         base;
    logic [15:0]        weight;
    logic               hold;
    logic               last;
  } joint_res_t;

  // directed stimulus row; typed rows carry a hand-read position/velocity
  typedef struct {
    bit          kind;
    logic [31:0] etime;
    logic [9:0]  frm;
    logic [4:0]  jnt;
    logic [15:0] ps;
    logic [15:0] vl;
    bit          typed;
    logic [15:0] exp_ps;
    logic [15:0] exp_vl;
  } dir_row_t;

  typedef struct {
    logic [10:0] fc;
    logic [5:0]  jc;
    logic [15:0] fr;
    logic [15:0] sp;
    logic        le;
    logic [31:0] lp;
  } setting_t;

  logic clk;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = CFG_FRAME_COUNT;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_kind = 1'b0;
  logic [31:0] in_elapsed_time = '0;
  logic [9:0] in_load_frame = '0;
  logic [4:0] in_load_joint = '0;
  logic signed [15:0] in_load_position = '0;
  logic signed [15:0] in_load_velocity = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [4:0] out_joint_index;
  logic signed [15:0] out_position;
  logic signed [15:0] out_velocity;
  logic [9:0] out_base_frame;
  logic [15:0] out_blend_weight;
  logic out_holding;
  logic out_last;

  trajectory_playback_interpolator_unit i_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_kind(in_kind),
    .in_elapsed_time(in_elapsed_time), .in_load_frame(in_load_frame),
    .in_load_joint(in_load_joint), .in_load_position(in_load_position),
    .in_load_velocity(in_load_velocity),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_joint_index(out_joint_index), .out_position(out_position),
    .out_velocity(out_velocity), .out_base_frame(out_base_frame),
    .out_blend_weight(out_blend_weight), .out_holding(out_holding),
    .out_last(out_last)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // watchdog
  initial begin
    #8ms;
    $display("trajectory_playback_interpolator_unit_tb: FAIL");
    $finish;
  end

  // shadow of the frame table and the registers
  logic signed [15:0] pos_mem [TBL_FRAMES*TBL_JOINTS];
  logic signed [15:0] vel_mem [TBL_FRAMES*TBL_JOINTS];
  bit                 loaded  [TBL_FRAMES*TBL_JOINTS];
  logic [10:0] m_fc = RST_FRAME_COUNT;
  logic [5:0]  m_jc = RST_JOINT_COUNT;
  logic [15:0] m_fr = RST_FRAME_RATE;
  logic [15:0] m_sp = RST_SPEED;
  logic        m_le = 1'b0;
  logic [31:0] m_lp = '0;

  joint_res_t joint_q[$];
  int  errors = 0;
  bit  quiet = 0;
  int  stall_left = 0;

  task automatic report_mismatch(input string what);
    errors++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  function automatic longint unsigned frames_eff();
    if (m_fc == 0) return 1;
    if (m_fc > TBL_FRAMES) return TBL_FRAMES;
    return m_fc;
  endfunction

  function automatic int joints_eff();
    if (m_jc == 0) return 1;
    if (m_jc > TBL_JOINTS) return TBL_JOINTS;
    return m_jc;
  endfunction

  // frame position -> blend frames, upper weight, hold flag
  function automatic void locate_frames(input logic [31:0] t, output logic [9:0] b,
                                        output logic [9:0] u, output logic [15:0] w,
                                        output bit hold);
    longint unsigned f, rs, p, ff, pz, lim, frac, ww, bb;
    f = frames_eff();
    rs = 64'(m_sp) * 64'(m_fr);
    p = 64'(t) * rs;
    ff = f << 36;
    if (m_le) begin
      pz = 64'(m_lp) * rs;
      if (pz <= ~64'd0 - ff) p = p % (ff + pz);
    end
    hold = (p >= ff);
    lim = (f - 1) << 36;
    if (hold || p > lim) p = lim;
    bb = p >> 36;
    b = bb[9:0];
    u = (bb + 1 < f) ? 10'(bb + 1) : 10'(f - 1);
    frac = p & ((64'd1 << 36) - 1);
    ww = (frac + (64'd1 << 19)) >> 20;
    if (ww > 65535) ww = 65535;
    w = ww[15:0];
  endfunction

  function automatic logic [15:0] clip16(input longint v);
    if (v > 32767) return 16'h7fff;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  // expected joint results of one sample request
  task automatic predict_playback(input logic [31:0] t);
    logic [9:0] b, u;
    logic [15:0] w;
    bit hold;
    int nj, i0, i1;
    longint wl, wh, pb, vb;
    joint_res_t r;
    locate_frames(t, b, u, w, hold);
    nj = joints_eff();
    wh = longint'(w);
    wl = 65536 - wh;
    for (int j = 0; j < nj; j++) begin
      i0 = b * TBL_JOINTS + j;
      i1 = u * TBL_JOINTS + j;
      pb = wl * longint'(pos_mem[i0]) + wh * longint'(pos_mem[i1]);
      vb = wl * longint'(vel_mem[i0]) + wh * longint'(vel_mem[i1]);
      r.jidx = j[4:0];
      r.pos = clip16((pb + 32768) >>> 16);
      r.vel = hold ? 16'sd0 : clip16((vb * longint'(m_sp) + (64'sd1 <<< 27)) >>> 28);
      r.base = b;
      r.weight = w;
      r.hold = hold;
      r.last = (j == nj - 1);
      joint_q.insert(joint_q.size(), r);
    end
  endtask

  // one request on in_*; valid stays up between back-to-back requests
  task automatic send_req(input bit kind, input logic [31:0] t, input logic [9:0] frm,
                          input logic [4:0] jnt, input logic [15:0] ps,
                          input logic [15:0] vl);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_kind = kind;
    in_elapsed_time = t;
    in_load_frame = frm;
    in_load_joint = jnt;
    in_load_position = ps;
    in_load_velocity = vl;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    if (!kind) begin
      pos_mem[frm * TBL_JOINTS + jnt] = ps;
      vel_mem[frm * TBL_JOINTS + jnt] = vl;
      loaded[frm * TBL_JOINTS + jnt] = 1;
    end else begin
      predict_playback(t);
    end
    @(negedge clk);
  endtask

  task automatic send_load(input logic [9:0] frm, input logic [4:0] jnt);
    send_req(1'b0, $urandom, frm, jnt, 16'($urandom), 16'($urandom));
  endtask

  // fill any table entry the sample will read, then sample
  task automatic send_sample(input logic [31:0] t);
    logic [9:0] b, u;
    logic [15:0] w;
    bit hold;
    locate_frames(t, b, u, w, hold);
    for (int j = 0; j < joints_eff(); j++) begin
      if (!loaded[b * TBL_JOINTS + j]) send_load(b, j[4:0]);
      if (!loaded[u * TBL_JOINTS + j]) send_load(u, j[4:0]);
    end
    send_req(1'b1, t, 10'($urandom), 5'($urandom), 16'($urandom), 16'($urandom));
  endtask

  // register writes only once the block has drained
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] v);
    in_valid = 1'b0;
    while (joint_q.size() != 0) @(posedge clk);
    repeat (80) @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = v;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_FRAME_COUNT: m_fc = v[10:0];
      CFG_JOINT_COUNT: m_jc = v[5:0];
      CFG_FRAME_RATE:  m_fr = v[15:0];
      CFG_SPEED:       m_sp = v[15:0];
      CFG_LOOP_EN:     m_le = v[0];
      CFG_PAUSE_TIME:  m_lp = v;
      default: ;
    endcase
  endtask

  task automatic apply_setting(input setting_t s);
    write_reg(CFG_FRAME_COUNT, 32'(s.fc));
    write_reg(CFG_JOINT_COUNT, 32'(s.jc));
    write_reg(CFG_FRAME_RATE, 32'(s.fr));
    write_reg(CFG_SPEED, 32'(s.sp));
    write_reg(CFG_LOOP_EN, 32'(s.le));
    write_reg(CFG_PAUSE_TIME, s.lp);
  endtask

  // mostly times inside the motion (and a bit past it), some fully random
  function automatic logic [31:0] pick_time();
    longint unsigned rs, span, r;
    rs = 64'(m_sp) * 64'(m_fr);
    if (rs == 0 || $urandom_range(0, 5) == 0) return $urandom;
    span = ((frames_eff() << 36) * (m_le ? 3 : 5) / 4) / rs;
    if (span > 64'hffff_ffff) span = 64'hffff_ffff;
    r = {$urandom, $urandom};
    return 32'(r % (span + 1));
  endfunction

  // result side: random stall bursts, none near the end
  always @(negedge clk) begin
    if (quiet) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 4) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 5);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    joint_res_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (joint_q.size() == 0) begin
        report_mismatch("joint result with nothing pending");
      end else begin
        e = joint_q.pop_front();
        if (out_joint_index !== e.jidx)
          report_mismatch($sformatf("joint_index %0d exp %0d", out_joint_index, e.jidx));
        if (out_position !== e.pos)
          report_mismatch($sformatf("j%0d position %0d exp %0d", e.jidx, out_position, e.pos));
        if (out_velocity !== e.vel)
          report_mismatch($sformatf("j%0d velocity %0d exp %0d", e.jidx, out_velocity, e.vel));
        if (out_base_frame !== e.base)
          report_mismatch($sformatf("j%0d base_frame %0d exp %0d", e.jidx, out_base_frame,
                                    e.base));
        if (out_blend_weight !== e.weight)
          report_mismatch($sformatf("j%0d blend_weight %0d exp %0d", e.jidx,
                                    out_blend_weight, e.weight));
        if (out_holding !== e.hold)
          report_mismatch($sformatf("j%0d holding %0b exp %0b", e.jidx, out_holding, e.hold));
        if (out_last !== e.last)
          report_mismatch($sformatf("j%0d last %0b exp %0b", e.jidx, out_last, e.last));
      end
    end
  end

  // directed rows run at the reset setting: one frame, one joint, unit speed
  dir_row_t dir_rows[] = '{
    '{0, 32'h0, 10'd0, 5'd0, 16'h7fff, 16'h8000, 0, 16'h0, 16'h0},
    '{1, 32'h0, 10'h3ff, 5'h1f, 16'h0, 16'h0, 1, 16'h7fff, 16'h8000},     // max pos, min vel
    '{1, 32'hffff_ffff, 10'd0, 5'd0, 16'hffff, 16'hffff, 1, 16'h7fff, 16'h0}, // past end
    '{0, 32'h0, 10'd0, 5'd0, 16'h8000, 16'h7fff, 0, 16'h0, 16'h0},
    '{1, 32'h0, 10'd0, 5'd0, 16'h0, 16'h0, 1, 16'h8000, 16'h7fff},
    '{1, 32'h0000_0800, 10'd0, 5'd0, 16'h0, 16'h0, 0, 16'h0, 16'h0},
    '{0, 32'h0, 10'h3ff, 5'h1f, 16'h7fff, 16'h8000, 0, 16'h0, 16'h0},   // far corner entry
    '{0, 32'h0, 10'd0, 5'd0, 16'h0, 16'h0, 0, 16'h0, 16'h0},
    '{1, 32'h0, 10'd0, 5'd0, 16'h0, 16'h0, 1, 16'h0, 16'h0},
    '{1, 32'h0001_0000, 10'd0, 5'd0, 16'h0, 16'h0, 1, 16'h0, 16'h0}     // holding
  };

  // register settings walked by the random part; extremes included
  setting_t settings[] = '{
    '{11'd4, 6'd3, 16'd12800, 16'd4096, 1'b0, 32'd0},
    '{11'd0, 6'd0, 16'd256, 16'd4096, 1'b1, 32'd0},                     // zero counts act as 1
    '{11'd2047, 6'd1, 16'hffff, 16'hffff, 1'b1, 32'hffff_ffff},         // clamped, huge cycle
    '{11'd8, 6'd5, 16'd0, 16'd4096, 1'b1, 32'd65536},                   // zero frame rate
    '{11'd6, 6'd2, 16'd3200, 16'd0, 1'b0, 32'd0},                       // zero speed
    '{11'd16, 6'd2, 16'd25600, 16'd8192, 1'b1, 32'd32768},              // loop with pause
    '{11'd1, 6'd63, 16'd12800, 16'hffff, 1'b0, 32'd0},                  // joints clamped
    '{11'd3, 6'd4, 16'd1, 16'd1, 1'b1, 32'd0},
    '{11'd5, 6'd3, 16'd60000, 16'd3000, 1'b1, 32'd100000}
  };

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[k]) begin
      send_req(dir_rows[k].kind, dir_rows[k].etime, dir_rows[k].frm, dir_rows[k].jnt,
               dir_rows[k].ps, dir_rows[k].vl);
      if (dir_rows[k].typed) begin
        joint_q[joint_q.size() - 1].pos = dir_rows[k].exp_ps;
        joint_q[joint_q.size() - 1].vel = dir_rows[k].exp_vl;
      end
    end

    foreach (settings[s]) begin
      apply_setting(settings[s]);
      if (s == settings.size() - 1) quiet = 1;
      for (int n = 0; n < 5; n++) begin
        if ($urandom_range(0, 4) == 0) send_load(10'($urandom), 5'($urandom));
        send_sample(pick_time());
      end
    end

    in_valid = 1'b0;
    while (joint_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("trajectory_playback_interpolator_unit_tb: PASS");
    end else begin
      $display("trajectory_playback_interpolator_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire

[trajectory_playback_interpolator_unit.f]
+incdir+rtl
rtl/tpi_pkg.sv
rtl/tpi_ctrl.sv
rtl/tpi_dp.sv
rtl/trajectory_playback_interpolator_unit.sv
bench/trajectory_playback_interpolator_unit_tb.sv
